// ----- rtl/slipb_pkg.sv -----
// ----------------------------------------------------------------------------
// slipb_pkg: shared types and constants of the instruction prefetch buffer
// Transaction layouts, operation and result codes, and line geometry.
// ----------------------------------------------------------------------------
package slipb_pkg;

   localparam int LINE_BYTES = 8;
   localparam int OPC_BYTES  = 4;

   localparam int ADDR_W     = 32;
   localparam int INSN_W     = 32;
   localparam int DATA_W     = 64;
   localparam int OPC_W      = OPC_BYTES * 8;
   localparam int LINE_IDX_W = $clog2(LINE_BYTES);

   localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'(LINE_BYTES - 1);

   localparam logic [1:0] OP_FETCH = 2'd0;
   localparam logic [1:0] OP_LINE  = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [1:0] KIND_REQ   = 2'd0;
   localparam logic [1:0] KIND_INSN  = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] fetch_addr;
      logic [DATA_W-1:0] line_data;
      logic              line_error;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] mem_addr;
      logic [INSN_W-1:0] insn_word;
      logic [ADDR_W-1:0] insn_addr;
   } rsp_type;

endpackage

// ----- rtl/single_line_insn_prefetch_buffer.sv -----
// ----------------------------------------------------------------------------
// single_line_insn_prefetch_buffer: one-line instruction prefetch buffer
// A request passes through the input register, then the result register, to the response.
// Throughput is one request transaction per cycle unless the response side stalls.
// The response register lets a new request enter while a response waits.
// Reset invalidates the held line and clears the miss state and both registers' valid flags.
// ----------------------------------------------------------------------------
module single_line_insn_prefetch_buffer import slipb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [ADDR_W-1:0] req_fetch_addr,
   input  logic [DATA_W-1:0] req_line_data,
   input  logic              req_line_error,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [ADDR_W-1:0] rsp_mem_addr,
   output logic [INSN_W-1:0] rsp_insn_word,
   output logic [ADDR_W-1:0] rsp_insn_addr
);

   req_type req_in_data;
   req_type stage_data;
   logic    stage_valid;
   logic    go;
   logic    core_has_rsp;
   rsp_type core_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_in_data.opcode     = req_opcode;
   assign req_in_data.fetch_addr = req_fetch_addr;
   assign req_in_data.line_data  = req_line_data;
   assign req_in_data.line_error = req_line_error;

   assign go = stage_valid && (!rsp_valid_ff || rsp_ready);

   slipb_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_in_data),
      .advance   (go),
      .out_valid (stage_valid),
      .out_data  (stage_data)
   );

   slipb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .req     (stage_data),
      .has_rsp (core_has_rsp),
      .rsp     (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (go && core_has_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_data_ff.kind;
   assign rsp_mem_addr  = rsp_data_ff.mem_addr;
   assign rsp_insn_word = rsp_data_ff.insn_word;
   assign rsp_insn_addr = rsp_data_ff.insn_addr;

endmodule

// ----- rtl/slipb_in_reg.sv -----
// ----------------------------------------------------------------------------
// slipb_in_reg: input register of the instruction prefetch buffer
// Captures one request transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module slipb_in_reg import slipb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   input  logic    advance,
   output logic    out_valid,
   output req_type out_data
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/slipb_core.sv -----
// ----------------------------------------------------------------------------
// slipb_core: line state and decision logic of the instruction prefetch buffer
// Holds the line and the miss state, and forms at most one response per request.
// ----------------------------------------------------------------------------
module slipb_core import slipb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  req_type req,
   output logic    has_rsp,
   output rsp_type rsp
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;

   typedef struct packed {
      logic              fits;
      logic [INSN_W-1:0] word;
      logic [INSN_W-1:0] low;
      logic [ADDR_W-1:0] next;
   } serve_type;

   function automatic serve_type serve(input logic [ADDR_W-1:0] addr,
                                       input logic [ADDR_W-1:0] base,
                                       input logic [DATA_W-1:0] store);
      serve_type             s;
      logic [LINE_IDX_W-1:0] index;
      logic [DATA_W-1:0]     bytes;
      logic [LINE_IDX_W:0]   pos;
      index  = LINE_IDX_W'(addr - base);
      bytes  = store >> {index, 3'b000};
      s.fits = ({1'b0, index} + (LINE_IDX_W + 1)'(OPC_BYTES))
               <= (LINE_IDX_W + 1)'(LINE_BYTES);
      s.word = INSN_W'(bytes[OPC_W-1:0]);
      s.low  = '0;
      for (int i = 0; i < OPC_BYTES; i++) begin
         pos = {1'b0, index} + (LINE_IDX_W + 1)'(i);
         if (pos < (LINE_IDX_W + 1)'(LINE_BYTES)) begin
            s.low[i*8 +: 8] = bytes[i*8 +: 8];
         end
      end
      s.next = (addr + ADDR_W'(LINE_BYTES - 1)) & ~LINE_MASK;
      return s;
   endfunction

   logic [DATA_W-1:0] line_store_ff, line_store_in;
   logic [ADDR_W-1:0] line_base_ff, line_base_in;
   logic              line_valid_ff, line_valid_in;
   logic [1:0]        phase_ff, phase_in;
   logic [ADDR_W-1:0] pending_addr_ff, pending_addr_in;
   logic [INSN_W-1:0] saved_low_ff, saved_low_in;

   logic [ADDR_W-1:0]     srv_addr;
   logic [DATA_W-1:0]     srv_store;
   serve_type             srv;
   logic                  do_serve;
   logic [ADDR_W-1:0]     hit_off;
   logic [ADDR_W-1:0]     merge_next;
   logic [LINE_IDX_W-1:0] merge_nb;
   logic [INSN_W-1:0]     merge_word;

   always_comb begin
      srv_addr   = (req.opcode == OP_FETCH) ? req.fetch_addr : pending_addr_ff;
      srv_store  = (req.opcode == OP_FETCH) ? line_store_ff : req.line_data;
      srv        = serve(srv_addr, line_base_ff, srv_store);
      hit_off    = req.fetch_addr - line_base_ff;
      merge_next = (pending_addr_ff + ADDR_W'(LINE_BYTES - 1)) & ~LINE_MASK;
      merge_nb   = LINE_IDX_W'(merge_next - pending_addr_ff);
      merge_word = saved_low_ff | (req.line_data[INSN_W-1:0] << {merge_nb, 3'b000});
      merge_word = INSN_W'(merge_word[OPC_W-1:0]);

      line_store_in   = line_store_ff;
      line_base_in    = line_base_ff;
      line_valid_in   = line_valid_ff;
      phase_in        = phase_ff;
      pending_addr_in = pending_addr_ff;
      saved_low_in    = saved_low_ff;
      has_rsp         = 1'b0;
      rsp             = '0;
      do_serve        = 1'b0;

      if (go) begin
         case (req.opcode)
            OP_FETCH: begin
               if (phase_ff == PH_IDLE) begin
                  if (line_valid_ff && (hit_off < ADDR_W'(LINE_BYTES))) begin
                     do_serve = 1'b1;
                  end else begin
                     line_base_in    = req.fetch_addr & ~LINE_MASK;
                     line_valid_in   = 1'b0;
                     pending_addr_in = req.fetch_addr;
                     phase_in        = PH_LOW;
                     has_rsp         = 1'b1;
                     rsp.kind        = KIND_REQ;
                     rsp.mem_addr    = req.fetch_addr & ~LINE_MASK;
                     rsp.insn_addr   = req.fetch_addr;
                  end
               end
            end
            OP_LINE: begin
               if (phase_ff != PH_IDLE) begin
                  has_rsp = 1'b1;
                  if (req.line_error) begin
                     line_valid_in = 1'b0;
                     phase_in      = PH_IDLE;
                     rsp.kind      = KIND_FAULT;
                     rsp.mem_addr  = line_base_ff;
                     rsp.insn_addr = pending_addr_ff;
                  end else begin
                     line_store_in = req.line_data;
                     line_valid_in = 1'b1;
                     if (phase_ff == PH_LOW) begin
                        do_serve = 1'b1;
                     end else begin
                        phase_in      = PH_IDLE;
                        rsp.kind      = KIND_INSN;
                        rsp.insn_word = merge_word;
                        rsp.insn_addr = pending_addr_ff;
                     end
                  end
               end
            end
            OP_FLUSH: begin
               line_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (do_serve) begin
         has_rsp       = 1'b1;
         rsp.insn_addr = srv_addr;
         if (srv.fits) begin
            phase_in      = PH_IDLE;
            rsp.kind      = KIND_INSN;
            rsp.insn_word = srv.word;
         end else begin
            saved_low_in    = srv.low;
            line_base_in    = srv.next;
            line_valid_in   = 1'b0;
            pending_addr_in = srv_addr;
            phase_in        = PH_HIGH;
            rsp.kind        = KIND_REQ;
            rsp.mem_addr    = srv.next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_base_ff    <= '0;
         line_valid_ff   <= 1'b0;
         phase_ff        <= PH_IDLE;
         pending_addr_ff <= '0;
         saved_low_ff    <= '0;
      end else begin
         line_base_ff    <= line_base_in;
         line_valid_ff   <= line_valid_in;
         phase_ff        <= phase_in;
         pending_addr_ff <= pending_addr_in;
         saved_low_ff    <= saved_low_in;
      end
      line_store_ff <= line_store_in;
   end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the single-line instruction prefetch buffer
// Drives fetch, line response, flush and unused-opcode transactions over
// valid/ready, predicts the line requests, delivered opcodes and faults in a
// small model of the line buffer, and checks every response in order under
// random sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import slipb_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned ITEM_TARGET = 800;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {FILL_IDLE, FILL_WAIT_LOW, FILL_WAIT_HIGH} fill_state_type;

   class line_buffer_model;
      logic [DATA_W-1:0] line_bytes;
      logic [ADDR_W-1:0] base;
      bit                valid;
      fill_state_type    state;
      logic [ADDR_W-1:0] wait_addr;
      logic [OPC_W-1:0]  low_bytes;
      rsp_type           expected_q[$];
      int unsigned       failures;
      int unsigned       n_req;
      int unsigned       n_insn;
      int unsigned       n_fault;

      function new();
         line_bytes = '0;
         base       = '0;
         valid      = 1'b0;
         state      = FILL_IDLE;
         wait_addr  = '0;
         low_bytes  = '0;
      endfunction

      function void push(logic [1:0] kind, logic [ADDR_W-1:0] maddr,
                         logic [INSN_W-1:0] word, logic [ADDR_W-1:0] iaddr);
         rsp_type r;
         r.kind      = kind;
         r.mem_addr  = maddr;
         r.insn_word = word;
         r.insn_addr = iaddr;
         expected_q.push_back(r);
      endfunction

      function void serve(logic [ADDR_W-1:0] addr);
         int unsigned       idx;
         int unsigned       nb;
         logic [DATA_W-1:0] bytes;
         logic [DATA_W-1:0] low_mask;
         logic [ADDR_W-1:0] next_line;
         idx   = int'((addr - base) & LINE_MASK);
         bytes = line_bytes >> (idx * 8);
         if (idx + OPC_BYTES <= LINE_BYTES) begin
            state = FILL_IDLE;
            push(KIND_INSN, '0, bytes[INSN_W-1:0], addr);
         end else begin
            nb        = LINE_BYTES - idx;
            low_mask  = (64'd1 << (nb * 8)) - 64'd1;
            next_line = (addr + ADDR_W'(LINE_BYTES - 1)) & ~LINE_MASK;
            bytes     = bytes & low_mask;
            low_bytes = bytes[OPC_W-1:0];
            base      = next_line;
            valid     = 1'b0;
            wait_addr = addr;
            state     = FILL_WAIT_HIGH;
            push(KIND_REQ, next_line, '0, addr);
         end
      endfunction

      // Returns 1 when the transaction had an effect on the buffer.
      function bit note_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] data, logic err);
         logic [ADDR_W-1:0] next_line;
         int unsigned       nb;
         logic [DATA_W-1:0] merged;
         case (op)
            OP_FETCH: begin
               if (state != FILL_IDLE) return 1'b0;
               if (valid && (addr - base) < ADDR_W'(LINE_BYTES)) begin
                  serve(addr);
               end else begin
                  base      = addr & ~LINE_MASK;
                  valid     = 1'b0;
                  wait_addr = addr;
                  state     = FILL_WAIT_LOW;
                  push(KIND_REQ, base, '0, addr);
               end
               return 1'b1;
            end
            OP_LINE: begin
               if (state == FILL_IDLE) return 1'b0;
               if (err) begin
                  valid = 1'b0;
                  state = FILL_IDLE;
                  push(KIND_FAULT, base, '0, wait_addr);
                  return 1'b1;
               end
               line_bytes = data;
               valid      = 1'b1;
               if (state == FILL_WAIT_LOW) begin
                  serve(wait_addr);
               end else begin
                  next_line = (wait_addr + ADDR_W'(LINE_BYTES - 1)) & ~LINE_MASK;
                  nb        = int'((next_line - wait_addr) & LINE_MASK);
                  merged    = {{(DATA_W-OPC_W){1'b0}}, low_bytes} | (line_bytes << (nb * 8));
                  state     = FILL_IDLE;
                  push(KIND_INSN, '0, merged[INSN_W-1:0], wait_addr);
               end
               return 1'b1;
            end
            OP_FLUSH: begin
               valid = 1'b0;
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            $error("response with none expected: kind %0d mem_addr %h insn_word %h insn_addr %h",
                   got.kind, got.mem_addr, got.insn_word, got.insn_addr);
            failures++;
            return;
         end
         exp = expected_q.pop_front();
         case (got.kind)
            KIND_REQ:   n_req++;
            KIND_INSN:  n_insn++;
            KIND_FAULT: n_fault++;
            default: ;
         endcase
         if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            failures++;
         end
         if (got.mem_addr !== exp.mem_addr) begin
            $error("mem_addr: expected %h, got %h", exp.mem_addr, got.mem_addr);
            failures++;
         end
         if (got.insn_word !== exp.insn_word) begin
            $error("insn_word: expected %h, got %h", exp.insn_word, got.insn_word);
            failures++;
         end
         if (got.insn_addr !== exp.insn_addr) begin
            $error("insn_addr: expected %h, got %h", exp.insn_addr, got.insn_addr);
            failures++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_opcode;
   logic [ADDR_W-1:0] req_fetch_addr;
   logic [DATA_W-1:0] req_line_data;
   logic              req_line_error;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_kind;
   logic [ADDR_W-1:0] rsp_mem_addr;
   logic [INSN_W-1:0] rsp_insn_word;
   logic [ADDR_W-1:0] rsp_insn_addr;

   line_buffer_model  model = new();
   int unsigned       send_idle_pct;
   int unsigned       rsp_stall_pct;
   int unsigned       cycles;
   int unsigned       sent;
   int unsigned       effective;
   logic [ADDR_W-1:0] last_fetch;

   single_line_insn_prefetch_buffer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_fetch_addr (req_fetch_addr),
      .req_line_data  (req_line_data),
      .req_line_error (req_line_error),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_mem_addr   (rsp_mem_addr),
      .rsp_insn_word  (rsp_insn_word),
      .rsp_insn_addr  (rsp_insn_addr)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind      = rsp_kind;
         got.mem_addr  = rsp_mem_addr;
         got.insn_word = rsp_insn_word;
         got.insn_addr = rsp_insn_addr;
         model.check_response(got);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, input logic err);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_opcode     = op;
      req_fetch_addr = addr;
      req_line_data  = data;
      req_line_error = err;
      do @(posedge clock); while (!req_ready);
      if (model.note_request(op, addr, data, err)) effective++;
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [1:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              err;
      int unsigned       r;
      data = {$urandom, $urandom};
      addr = $urandom;
      err  = $urandom_range(1);
      r    = $urandom_range(99);
      if (model.state == FILL_IDLE) begin
         if (r < 75) begin
            op = OP_FETCH;
            r  = $urandom_range(99);
            if (model.valid && r < 45)
               addr = model.base + ADDR_W'($urandom_range(LINE_BYTES - 1));
            else if (r < 65)
               addr = last_fetch + ADDR_W'($urandom_range(OPC_BYTES, 1));
            else if (r < 75)
               addr = 32'hFFFF_FFF8 + ADDR_W'($urandom_range(15));
            last_fetch = addr;
         end else if (r < 85) begin
            op = OP_FLUSH;
         end else if (r < 93) begin
            op = OP_LINE;
         end else begin
            op = OP_UNUSED;
         end
      end else begin
         if (r < 85) begin
            op  = OP_LINE;
            err = ($urandom_range(99) < 8);
         end else if (r < 92) begin
            op = OP_FETCH;
         end else if (r < 97) begin
            op = OP_FLUSH;
         end else begin
            op = OP_UNUSED;
         end
      end
      send_item(op, addr, data, err);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_FETCH;
      req_fetch_addr = '0;
      req_line_data  = '0;
      req_line_error = 1'b0;
      rsp_ready      = 1'b0;
      send_idle_pct  = 21;
      rsp_stall_pct  = 83;
      last_fetch     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(OP_LINE,   32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(OP_LINE,   32'hFFFF_FFFF, 64'h0,                   1'b1);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(OP_FLUSH,  32'h0000_0000, 64'h0,                   1'b0);
      send_item(OP_FETCH,  32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(OP_FETCH,  32'h0000_0100, 64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'h0123_4567_89AB_CDEF, 1'b0);
      send_item(OP_FETCH,  32'h0000_0004, 64'h0,                   1'b0);
      send_item(OP_FETCH,  32'h0000_0005, 64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'hFEDC_BA98_7654_3210, 1'b0);
      send_item(OP_FETCH,  32'h0000_0008, 64'h0,                   1'b0);
      send_item(OP_FLUSH,  32'h0,         64'h0,                   1'b0);
      send_item(OP_FETCH,  32'h0000_000C, 64'h0,                   1'b0);
      send_item(OP_FLUSH,  32'h0,         64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'h1111_2222_3333_4444, 1'b1);
      send_item(OP_FETCH,  32'hFFFF_FFFF, 64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(OP_LINE,   32'h0,         64'h0,                   1'b0);
      send_item(OP_FETCH,  32'hFFFF_FFFE, 64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'hA5A5_5A5A_C3C3_3C3C, 1'b0);
      send_item(OP_LINE,   32'h0,         64'h0,                   1'b1);
      send_item(OP_FETCH,  32'h8000_0006, 64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'h8877_6655_4433_2211, 1'b0);
      send_item(OP_FLUSH,  32'h0,         64'h0,                   1'b0);
      send_item(OP_LINE,   32'h0,         64'hDEAD_BEEF_CAFE_F00D, 1'b0);

      while (sent < ITEM_TARGET) begin
         if (sent == ITEM_TARGET / 3) begin
            send_idle_pct = 83;
            rsp_stall_pct = 21;
         end else if (sent == 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         send_random();
      end
      req_valid = 1'b0;

      while (model.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d transactions in %0d cycles, %0d of them acted on by the buffer.",
               sent, cycles, effective);
      $display("Checked %0d line requests, %0d delivered opcodes and %0d fetch faults.",
               model.n_req, model.n_insn, model.n_fault);
      if (model.failures == 0 && model.expected_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
